/* src/dht_pkg.sv */
// Package with widths, codes, types and defaults shared by the hash table files.
`default_nettype none
package dht_pkg;

	localparam int DEF_TABLE_DEPTH = 1024;
	localparam int DEF_KEY_BITS = 16;
	localparam int DEF_QUEUE_DEPTH = 2;

	localparam int KIND_W = 2;
	localparam int KEY_W = 16;
	localparam int AGE_W = 8;
	localparam int WEIGHT_W = 16;
	localparam int HEIGHT_W = 10;
	localparam int STATUS_W = 2;
	localparam int SLOT_W = 10;
	localparam int SIZE_W = 11;
	localparam int REC_W = AGE_W + WEIGHT_W + HEIGHT_W;
	localparam int SST_W = 2;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);
	localparam int SIZE_MIN = 2;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

	localparam logic [SST_W-1:0] SLOT_FREE = 2'd0;
	localparam logic [SST_W-1:0] SLOT_USED = 2'd1;
	localparam logic [SST_W-1:0] SLOT_GONE = 2'd2;

	typedef struct packed {
		logic [AGE_W-1:0] age;
		logic [WEIGHT_W-1:0] weight;
		logic [HEIGHT_W-1:0] height;
	} rec_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_READ,
		B_EVAL
	} back_state_t;

endpackage
`default_nettype wire

/* src/dht_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* src/dht_front.sv */
// Front end: accepts items and works out both hashes by bit-serial remainders.
`default_nettype none
module dht_front #(
	parameter int TABLE_DEPTH = dht_pkg::DEF_TABLE_DEPTH,
	parameter int KEY_BITS = dht_pkg::DEF_KEY_BITS,
	localparam int IW = $clog2(TABLE_DEPTH),
	localparam int MW = $clog2(TABLE_DEPTH + 1),
	localparam int ITEM_W = dht_pkg::KIND_W + KEY_BITS + dht_pkg::REC_W + IW + MW
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic enable,
	input wire logic [MW-1:0] m,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [dht_pkg::KIND_W-1:0] in_kind,
	input wire logic [KEY_BITS-1:0] in_key,
	input wire dht_pkg::rec_t in_rec,
	output logic push_valid,
	input wire logic push_ready,
	output logic [ITEM_W-1:0] push_data
);

	localparam int BW = $clog2(KEY_BITS);

	dht_pkg::front_state_t state_q, state_d;
	logic [dht_pkg::KIND_W-1:0] kind_q;
	logic [KEY_BITS-1:0] key_q;
	dht_pkg::rec_t rec_q;
	logic [MW-1:0] rem1_q, rem2_q;
	logic [BW-1:0] bit_q;
	logic [MW:0] t1, t2;
	logic [MW-1:0] d2;
	logic [MW-1:0] h2;

	assign d2 = m - MW'(1);
	assign t1 = {rem1_q, key_q[bit_q]};
	assign t2 = {rem2_q, key_q[bit_q]};
	assign h2 = rem2_q + MW'(1);
	assign push_data = {kind_q, key_q, rec_q, rem1_q[IW-1:0], h2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dht_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			dht_pkg::F_IDLE: begin
				if (in_valid && in_ready) begin
					kind_q <= in_kind;
					key_q <= in_key;
					rec_q <= in_rec;
					rem1_q <= '0;
					rem2_q <= '0;
					bit_q <= BW'(KEY_BITS - 1);
				end
			end
			dht_pkg::F_DIV: begin
				rem1_q <= (t1 >= {1'b0, m}) ? MW'(t1 - {1'b0, m}) : t1[MW-1:0];
				rem2_q <= (t2 >= {1'b0, d2}) ? MW'(t2 - {1'b0, d2}) : t2[MW-1:0];
				bit_q <= bit_q - BW'(1);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		push_valid = 1'b0;
		case (state_q)
			dht_pkg::F_IDLE: begin
				in_ready = enable;
				if (in_valid && enable) begin
					state_d = dht_pkg::F_DIV;
				end
			end
			dht_pkg::F_DIV: begin
				if (bit_q == '0) begin
					state_d = dht_pkg::F_PUSH;
				end
			end
			dht_pkg::F_PUSH: begin
				push_valid = 1'b1;
				if (push_ready) begin
					state_d = dht_pkg::F_IDLE;
				end
			end
			default: begin
				state_d = dht_pkg::F_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

/* src/dht_queue.sv */
// Short register queue between the front end and the probe engine.
`default_nettype none
module dht_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = dht_pkg::DEF_QUEUE_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push_valid,
	output logic push_ready,
	input wire logic [WIDTH-1:0] push_data,
	output logic pop_valid,
	input wire logic pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic push, pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data = entry_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* src/dht_back.sv */
// Probe engine: clears the table after reset and walks each item's probe sequence.
`default_nettype none
module dht_back #(
	parameter int TABLE_DEPTH = dht_pkg::DEF_TABLE_DEPTH,
	parameter int KEY_BITS = dht_pkg::DEF_KEY_BITS,
	localparam int IW = $clog2(TABLE_DEPTH),
	localparam int MW = $clog2(TABLE_DEPTH + 1),
	localparam int ITEM_W = dht_pkg::KIND_W + KEY_BITS + dht_pkg::REC_W + IW + MW
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [MW-1:0] m,
	output logic ready_for_items,
	input wire logic pop_valid,
	output logic pop_ready,
	input wire logic [ITEM_W-1:0] pop_data,
	output logic out_valid,
	input wire logic out_ready,
	output logic [dht_pkg::STATUS_W-1:0] out_status,
	output logic [dht_pkg::SLOT_W-1:0] out_slot,
	output dht_pkg::rec_t out_rec
);

	localparam int WORD_W = dht_pkg::SST_W + KEY_BITS + dht_pkg::REC_W;

	dht_pkg::back_state_t state_q, state_d;
	logic [IW-1:0] clr_cnt_q;
	logic [dht_pkg::KIND_W-1:0] kind_q;
	logic [KEY_BITS-1:0] key_q;
	dht_pkg::rec_t rec_q;
	logic [IW-1:0] pos_q;
	logic [MW-1:0] step_q;
	logic [MW-1:0] cnt_q;
	logic out_valid_q;
	logic [dht_pkg::STATUS_W-1:0] status_q;
	logic [dht_pkg::SLOT_W-1:0] slot_q;
	dht_pkg::rec_t found_q;

	logic [dht_pkg::KIND_W-1:0] pop_kind;
	logic [KEY_BITS-1:0] pop_key;
	dht_pkg::rec_t pop_rec;
	logic [IW-1:0] pop_h1;
	logic [MW-1:0] pop_h2;

	logic ram_we;
	logic [IW-1:0] ram_waddr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata;
	logic [dht_pkg::SST_W-1:0] rd_state;
	logic [KEY_BITS-1:0] rd_key;
	dht_pkg::rec_t rd_rec;

	logic [MW-1:0] cnt_nx;
	logic last_probe;
	logic [MW:0] sum;
	logic [MW:0] sum_red;
	logic [31:0] pos_w;
	logic finish;
	logic [dht_pkg::STATUS_W-1:0] fin_status;
	dht_pkg::rec_t fin_rec;

	assign {pop_kind, pop_key, pop_rec, pop_h1, pop_h2} = pop_data;
	assign {rd_state, rd_key, rd_rec} = ram_rdata;

	dht_ram #(
		.WIDTH(WORD_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(pos_q),
		.rdata(ram_rdata)
	);

	assign cnt_nx = cnt_q + MW'(1);
	assign last_probe = (cnt_nx == m);
	assign sum = {1'b0, MW'(pos_q)} + {1'b0, step_q};
	assign sum_red = (sum >= {1'b0, m}) ? sum - {1'b0, m} : sum;
	assign pos_w = 32'(pos_q);

	assign ready_for_items = (state_q != dht_pkg::B_CLEAR);
	assign out_valid = out_valid_q;
	assign out_status = status_q;
	assign out_slot = slot_q;
	assign out_rec = found_q;

	always_comb begin
		state_d = state_q;
		pop_ready = 1'b0;
		ram_we = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = '0;
		finish = 1'b0;
		fin_status = dht_pkg::STATUS_MISSING;
		fin_rec = '0;
		case (state_q)
			dht_pkg::B_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_cnt_q;
				if (clr_cnt_q == IW'(TABLE_DEPTH - 1)) begin
					state_d = dht_pkg::B_IDLE;
				end
			end
			dht_pkg::B_IDLE: begin
				pop_ready = !out_valid_q;
				if (pop_valid && !out_valid_q) begin
					state_d = dht_pkg::B_READ;
				end
			end
			dht_pkg::B_READ: begin
				state_d = dht_pkg::B_EVAL;
			end
			dht_pkg::B_EVAL: begin
				case (kind_q)
					dht_pkg::KIND_INSERT: begin
						if (rd_state != dht_pkg::SLOT_USED) begin
							finish = 1'b1;
							fin_status = dht_pkg::STATUS_DONE;
							ram_we = 1'b1;
							ram_wdata = {dht_pkg::SLOT_USED, key_q, rec_q};
						end else if (last_probe) begin
							finish = 1'b1;
							fin_status = dht_pkg::STATUS_FULL;
						end
					end
					dht_pkg::KIND_SEARCH, dht_pkg::KIND_REMOVE: begin
						if (rd_state == dht_pkg::SLOT_USED && rd_key == key_q) begin
							finish = 1'b1;
							fin_status = dht_pkg::STATUS_DONE;
							if (kind_q == dht_pkg::KIND_SEARCH) begin
								fin_rec = rd_rec;
							end else begin
								ram_we = 1'b1;
								ram_wdata = {dht_pkg::SLOT_GONE, {KEY_BITS{1'b0}},
									{dht_pkg::REC_W{1'b0}}};
							end
						end else if (rd_state == dht_pkg::SLOT_FREE || last_probe) begin
							finish = 1'b1;
						end
					end
					default: begin
						finish = 1'b1;
					end
				endcase
				state_d = finish ? dht_pkg::B_IDLE : dht_pkg::B_READ;
			end
			default: begin
				state_d = dht_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dht_pkg::B_CLEAR;
			clr_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == dht_pkg::B_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + IW'(1);
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			kind_q <= pop_kind;
			key_q <= pop_key;
			rec_q <= pop_rec;
			pos_q <= pop_h1;
			step_q <= pop_h2;
			cnt_q <= '0;
		end else if (state_q == dht_pkg::B_EVAL && !finish) begin
			pos_q <= sum_red[IW-1:0];
			cnt_q <= cnt_nx;
		end
		if (finish) begin
			status_q <= fin_status;
			slot_q <= (fin_status == dht_pkg::STATUS_DONE) ? pos_w[dht_pkg::SLOT_W-1:0] : '0;
			found_q <= fin_rec;
		end
	end

`ifndef SYNTH
	a_cnt_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dht_pkg::B_EVAL) |-> (cnt_q < m))
		else $error("Probe count reached the table size.");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dht_pkg::B_READ) |-> (MW'(pos_q) < m))
		else $error("Probe position outside the slots in use.");

	a_result_from_eval: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == dht_pkg::B_EVAL))
		else $error("Result appeared without a finished probe.");

	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != dht_pkg::STATUS_DONE) |-> (slot_q == '0 && found_q == '0))
		else $error("Failed item carries a slot or record.");
`endif

endmodule
`default_nettype wire

/* src/double_hash_table_core.sv */
// Top level of the double-hashing open-addressing hash table.
`default_nettype none
// Insert, search and remove items on an open-addressing table of up to TABLE_DEPTH slots,
// of which table_size are in use (clamped to 2..TABLE_DEPTH); probe i visits
// (key mod m + i * (1 + key mod (m-1))) mod m, and every item gives exactly one result.
// After reset the table is cleared one slot per cycle, during which in_ready stays low;
// configuration writes are taken at any time. The front end computes both remainders
// one key bit per cycle; the probe engine then takes each item from the queue, makes a
// registered read of the single table memory and a check for each probe, and hands over
// the result before it takes the next item. A two-entry queue lets the two run on
// different items, so the front end can work on one item while the probe engine
// handles an earlier one.
module double_hash_table_core #(
	parameter int TABLE_DEPTH = dht_pkg::DEF_TABLE_DEPTH,
	parameter int KEY_BITS = dht_pkg::DEF_KEY_BITS,
	parameter int QUEUE_DEPTH = dht_pkg::DEF_QUEUE_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [dht_pkg::SIZE_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [dht_pkg::KIND_W-1:0] kind,
	input wire logic [dht_pkg::KEY_W-1:0] key,
	input wire logic [dht_pkg::AGE_W-1:0] age,
	input wire logic [dht_pkg::WEIGHT_W-1:0] weight,
	input wire logic [dht_pkg::HEIGHT_W-1:0] height,
	output logic out_valid,
	input wire logic out_ready,
	output logic [dht_pkg::STATUS_W-1:0] status,
	output logic [dht_pkg::SLOT_W-1:0] slot,
	output logic [dht_pkg::AGE_W-1:0] found_age,
	output logic [dht_pkg::WEIGHT_W-1:0] found_weight,
	output logic [dht_pkg::HEIGHT_W-1:0] found_height
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int MW = $clog2(TABLE_DEPTH + 1);
	localparam int ITEM_W = dht_pkg::KIND_W + KEY_BITS + dht_pkg::REC_W + IW + MW;

	logic [dht_pkg::SIZE_W-1:0] table_size_q;
	logic [31:0] size_w, m_w, key_w;
	logic [MW-1:0] m;
	logic [KEY_BITS-1:0] key_k;
	dht_pkg::rec_t in_rec, out_rec;
	logic enable;
	logic push_valid, push_ready, pop_valid, pop_ready;
	logic [ITEM_W-1:0] push_data, pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= dht_pkg::SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			table_size_q <= cfg_data;
		end
	end

	always_comb begin
		size_w = 32'(table_size_q);
		if (size_w < 32'(dht_pkg::SIZE_MIN)) begin
			m_w = 32'(dht_pkg::SIZE_MIN);
		end else if (size_w > 32'(TABLE_DEPTH)) begin
			m_w = 32'(TABLE_DEPTH);
		end else begin
			m_w = size_w;
		end
	end

	assign m = m_w[MW-1:0];
	assign key_w = 32'(key);
	assign key_k = key_w[KEY_BITS-1:0];
	assign in_rec = '{age: age, weight: weight, height: height};

	dht_front #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.KEY_BITS(KEY_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.enable(enable),
		.m(m),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_kind(kind),
		.in_key(key_k),
		.in_rec(in_rec),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data)
	);

	dht_queue #(
		.WIDTH(ITEM_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data)
	);

	dht_back #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.KEY_BITS(KEY_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.m(m),
		.ready_for_items(enable),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_status(status),
		.out_slot(slot),
		.out_rec(out_rec)
	);

	assign found_age = out_rec.age;
	assign found_weight = out_rec.weight;
	assign found_height = out_rec.height;

endmodule
`default_nettype wire
